// ----- rtl/lr_pkg.sv -----
// Package for the line rasterizer: default widths and the command/status
// structs that pass between the controller and the datapath.
// No dependencies.
package lr_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // input transfer kinds carried on tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // commands from the controller, at most one set per cycle
    typedef struct packed {
        logic capture;   // latch endpoints and their differences
        logic load;      // set up the line from the latched endpoints
        logic div_init;  // start the fraction division for the current pixel
        logic div_step;  // one quotient bit
        logic emit;      // write the pixel to the output register and advance
    } t_cmd;

    typedef struct packed {
        logic line_active;
        logic out_free;   // output register can take a pixel this cycle
        logic at_last;    // current pixel is the final one of the line
    } t_sts;

endpackage

// ----- rtl/lr_ctrl.sv -----
// Controller for the line rasterizer: sequences load, fraction division and
// pixel emission. Depends on lr_pkg.
module lr_ctrl #(
    parameter int FRACTION_BITS = lr_pkg::FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mode,
    output logic          o_ready,
    input  lr_pkg::t_sts  i_sts,
    output lr_pkg::t_cmd  o_cmd
);
    import lr_pkg::*;

    localparam int CntW = $clog2(FRACTION_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_LOAD;
                    end else if (i_sts.line_active) begin
                        o_cmd.div_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_DIV;
                    end
                    // a request with no line gives nothing: drop it
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CntW'(FRACTION_BITS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/lr_dpath.sv -----
// Datapath for the line rasterizer: endpoint set-up, incremental minor-axis
// quotient and remainder, bit-serial fraction divider and output register.
// Depends on lr_pkg.
module lr_dpath #(
    parameter int  COORD_BITS    = lr_pkg::COORD_BITS_DEF,
    parameter int  FRACTION_BITS = lr_pkg::FRACTION_BITS_DEF,
    localparam int InW           = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OutW          = ((2 * COORD_BITS + FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lr_pkg::t_cmd    i_cmd,
    output lr_pkg::t_sts    o_sts,
    input  logic [InW-1:0]  i_tdata,
    output logic [OutW-1:0] o_tdata,
    output logic            o_tlast,
    output logic            o_tvalid,
    input  logic            i_tready
);
    import lr_pkg::*;

    localparam int C = COORD_BITS;
    localparam int F = FRACTION_BITS;

    // latched endpoints and differences
    logic signed [C-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [C:0]   r_dx, r_dy;

    // line state
    logic signed [C-1:0] r_org_maj, r_org_min;
    logic        [C-1:0] r_dmaj;
    logic signed [C:0]   r_dmin;
    logic        [C-1:0] r_k;
    logic signed [C:0]   r_quot;
    logic        [C-1:0] r_rem;
    logic                r_maj_y, r_from_b, r_active;

    // fraction divider
    logic        [C-1:0] r_div_rem;
    logic        [F-1:0] r_div_q;
    logic                r_full;

    // output register
    logic                r_out_valid, r_out_last;
    logic        [OutW-1:0] r_out_data;

    // ---------------- set-up from latched endpoints ----------------
    logic signed [C:0]   adx, ady, dmaj_d, dmin_d;
    logic        [C-1:0] adx_u, ady_u;
    logic                maj_y, fwd;

    always_comb begin
        adx    = r_dx[C] ? -r_dx : r_dx;
        ady    = r_dy[C] ? -r_dy : r_dy;
        adx_u  = adx[C-1:0];
        ady_u  = ady[C-1:0];
        maj_y  = ady_u > adx_u;
        dmaj_d = maj_y ? r_dy : r_dx;
        dmin_d = maj_y ? r_dx : r_dy;
        fwd    = !dmaj_d[C] && (dmaj_d != '0);
    end

    // ---------------- current pixel ----------------
    logic signed [C+1:0] minr, minr_raw;
    logic signed [C:0]   maj;
    logic        [C-1:0] from_a;
    logic        [C-1:0] px, py;
    logic        [F:0]   frac;
    logic                at_last;

    always_comb begin
        minr_raw = (C+2)'(r_org_min) + (C+2)'(r_quot);
        minr     = (minr_raw[C+1] && (r_rem != '0)) ? minr_raw + (C+2)'(1) : minr_raw;
        maj      = (C+1)'(r_org_maj) + $signed({1'b0, r_k});
        px       = r_maj_y ? minr[C-1:0] : maj[C-1:0];
        py       = r_maj_y ? maj[C-1:0]  : minr[C-1:0];
        from_a   = r_from_b ? r_dmaj - r_k : r_k;
        frac     = r_full ? {1'b1, {F{1'b0}}} : {1'b0, r_div_q};
        at_last  = (r_k == r_dmaj);
    end

    // ---------------- remainder advance ----------------
    logic signed [C+1:0] rem_sum, dmaj_s;
    logic        [C-1:0] n_rem;
    logic signed [C:0]   n_quot;

    always_comb begin
        dmaj_s  = $signed({2'b00, r_dmaj});
        rem_sum = $signed({2'b00, r_rem}) + (C+2)'(r_dmin);
        n_quot  = r_quot;
        n_rem   = rem_sum[C-1:0];
        if (rem_sum >= dmaj_s) begin
            n_rem  = C'(rem_sum - dmaj_s);
            n_quot = r_quot + (C+1)'(1);
        end else if (rem_sum[C+1]) begin
            n_rem  = C'(rem_sum + dmaj_s);
            n_quot = r_quot - (C+1)'(1);
        end
    end

    // ---------------- divider step ----------------
    logic [C:0] div_sh;
    logic       div_ge;

    always_comb begin
        div_sh = {r_div_rem, 1'b0};
        div_ge = div_sh >= {1'b0, r_dmaj};
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_active <= (maj_y ? ady_u : adx_u) != '0;
            end else if (i_cmd.emit && at_last) begin
                r_active <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_tdata[C-1:0];
            r_ay <= i_tdata[2*C-1:C];
            r_bx <= i_tdata[3*C-1:2*C];
            r_by <= i_tdata[4*C-1:3*C];
            r_dx <= $signed(i_tdata[3*C-1:2*C]) - $signed(i_tdata[C-1:0]);
            r_dy <= $signed(i_tdata[4*C-1:3*C]) - $signed(i_tdata[2*C-1:C]);
        end
        if (i_cmd.load) begin
            r_maj_y   <= maj_y;
            r_from_b  <= !fwd;
            r_dmaj    <= maj_y ? ady_u : adx_u;
            r_dmin    <= fwd ? dmin_d : -dmin_d;
            r_org_maj <= fwd ? (maj_y ? r_ay : r_ax) : (maj_y ? r_by : r_bx);
            r_org_min <= fwd ? (maj_y ? r_ax : r_ay) : (maj_y ? r_bx : r_by);
            r_k       <= '0;
            r_quot    <= '0;
            r_rem     <= '0;
        end else if (i_cmd.emit && !at_last) begin
            r_k    <= r_k + 1'b1;
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
        if (i_cmd.div_init) begin
            r_div_rem <= from_a;
            r_div_q   <= '0;
            r_full    <= (from_a == r_dmaj);
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? C'(div_sh - {1'b0, r_dmaj}) : div_sh[C-1:0];
            r_div_q   <= {r_div_q[F-2:0], div_ge};
        end
        if (i_cmd.emit) begin
            r_out_data <= OutW'({frac, py, px});
            r_out_last <= at_last;
        end
    end

    assign o_sts.line_active = r_active;
    assign o_sts.out_free    = !r_out_valid || i_tready;
    assign o_sts.at_last     = at_last;

    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;
    assign o_tvalid = r_out_valid;

endmodule

// ----- rtl/line_rasterizer_with_gradient_fraction.sv -----
// Line rasterizer with gradient fraction. A transfer with tuser low loads endpoints
// A and B (captured, then set up; no result); a transfer with tuser high asks for the
// next pixel of the loaded line and gives one result, or nothing once the line is
// finished or when none is loaded. Pixels run along the major axis from the lower
// end, both endpoints included, and each carries its distance from A as a fraction
// of the line in Q1.16 (Q1.FRACTION_BITS). A pixel request is accepted, then the
// bit-serial fraction divider gives one quotient bit per step, then the pixel is
// written to the output register once it is free. The output register lets the next
// request be accepted while a pixel still waits to be taken.
// Depends on lr_pkg, lr_ctrl and lr_dpath.
module line_rasterizer_with_gradient_fraction #(
    parameter int  COORD_BITS    = lr_pkg::COORD_BITS_DEF,
    parameter int  FRACTION_BITS = lr_pkg::FRACTION_BITS_DEF,
    localparam int InW           = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OutW          = ((2 * COORD_BITS + FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [InW-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
    input  logic            s_axis_tuser,   // mode
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [OutW-1:0] m_axis_tdata,   // pixel_x, pixel_y, blend_fraction
    output logic            m_axis_tlast    // last_pixel
);
    import lr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lr_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lr_dpath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_tdata  (s_axis_tdata),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready)
    );

    // a pixel is only produced for an active line
    a_emit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.line_active)
        else $error("pixel emitted with no active line");

    // never overwrite a pixel still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // the final pixel ends the line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && sts.at_last) |=> (!sts.line_active && m_axis_tlast))
        else $error("line still active after final pixel");

    // a pixel appears on the output the cycle after it is emitted
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("emitted pixel not presented");

endmodule
